/* hdl/assert_macros.svh */
// assertion macros used by the top-level rtl file
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property that holds in every cycle out of reset
`define ASSERT_ALWAYS(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// condition in one cycle implies a result in the next
`define ASSERT_NEXT(label, clk, rst_n, cond, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error(msg);

`endif

/* hdl/gfsld_pkg.sv */
// types, codes and helpers for the gap framed serial line decoder
// no dependencies
`default_nettype none

package gfsld_pkg;

    localparam int WINDOW_W     = 32;
    localparam int CFG_INDEX_W  = 3;
    localparam int CFG_DATA_W   = 32;
    localparam int WORD_LEN_MIN = 8;
    localparam int WORD_LEN_MAX = 16;

    localparam logic [7:0] PRINT_LO    = 8'h20;
    localparam logic [7:0] PRINT_END   = 8'h7F;
    localparam logic [7:0] GARBLE_CHAR = 8'h3F;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_FRAME_GAP     = 3'd0,
        CFG_DATA_LANE     = 3'd1,
        CFG_WORD_LENGTH   = 3'd2,
        CFG_MSB_FIRST     = 3'd3,
        CFG_MARKER_FIRST  = 3'd4,
        CFG_MARKER_SECOND = 3'd5,
        CFG_COLUMN_LIMIT  = 3'd6
    } cfg_index_t;

    typedef enum logic {
        OP_EDGE  = 1'b0,
        OP_FLUSH = 1'b1
    } op_t;

    typedef enum logic {
        KIND_CHAR    = 1'b0,
        KIND_SUMMARY = 1'b1
    } kind_t;

    typedef struct packed {
        logic       kind;
        logic [1:0] line_index;
        logic [4:0] column;
        logic [7:0] char_code;
        logic       garbled;
        logic       line_full;
        logic [9:0] frame_bits;
        logic [2:0] frame_lines;
        logic       frame_overflow;
        logic [7:0] frame_garbled;
    } result_t;

    // payload byte of the word ending 'back' bits before the newest bit
    function automatic logic [7:0] payload(input logic [WINDOW_W-1:0] win,
                                           input logic [4:0] back,
                                           input logic msb);
        logic [7:0] raw;
        logic [7:0] rev;
        raw = 8'(win >> back);
        for (int k = 0; k < 8; k++)
        begin
            rev[k] = raw[7-k];
        end
        return msb ? raw : rev;
    endfunction

endpackage

`default_nettype wire

/* hdl/gfsld_if.sv */
// handshake interfaces for sample, result and configuration words
// depends on gfsld_pkg
`default_nettype none

interface gfsld_sample_if;
    logic        valid;
    logic        ready;
    logic        operation;
    logic [31:0] port_word;
    logic [31:0] edge_time_us;

    modport source (output valid, output operation, output port_word,
                    output edge_time_us, input ready);
    modport sink   (input valid, input operation, input port_word,
                    input edge_time_us, output ready);
endinterface

interface gfsld_result_if;
    logic       valid;
    logic       ready;
    logic       kind;
    logic [1:0] line_index;
    logic [4:0] column;
    logic [7:0] char_code;
    logic       garbled;
    logic       line_full;
    logic [9:0] frame_bits;
    logic [2:0] frame_lines;
    logic       frame_overflow;
    logic [7:0] frame_garbled;

    modport source (output valid, output kind, output line_index, output column,
                    output char_code, output garbled, output line_full,
                    output frame_bits, output frame_lines, output frame_overflow,
                    output frame_garbled, input ready);
    modport sink   (input valid, input kind, input line_index, input column,
                    input char_code, input garbled, input line_full,
                    input frame_bits, input frame_lines, input frame_overflow,
                    input frame_garbled, output ready);
endinterface

interface gfsld_cfg_if
    import gfsld_pkg::*;
;
    logic                   valid;
    logic                   ready;
    logic [CFG_INDEX_W-1:0] index;
    logic [CFG_DATA_W-1:0]  data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

/* hdl/gap_framed_serial_line_decoder_top.sv */
// gap framed serial line decoder, top level
// depends on gfsld_pkg, gfsld_if.sv and assert_macros.svh
//
//  channel  dir  word
//  sample   in   operation, port_word, edge_time_us
//  result   out  character or end-of-frame summary
//  cfg      in   register index and write data
//
// one sample word accepted per cycle while sample ready is high, its result registered into the output buffer
// a two-entry output buffer lets one more word in while a result is stalled
// sample ready drops only while both output entries are full
// cfg ready is always high; all control state clears on rst_n
`default_nettype none
`include "assert_macros.svh"

module gap_framed_serial_line_decoder_top
    import gfsld_pkg::*;
#(
    parameter int FRAME_BITS_MAX = 512,
    parameter int LINES_MAX      = 4,
    parameter int COLUMNS_MAX    = 32
)(
    input  wire              clk,
    input  wire              rst_n,
    gfsld_cfg_if.sink        cfg,
    gfsld_sample_if.sink     sample,
    gfsld_result_if.source   result
);

    localparam int BCW = $clog2(FRAME_BITS_MAX + 1);
    localparam int NWW = $clog2(FRAME_BITS_MAX + WORD_LEN_MAX + 1);
    localparam int CCW = $clog2(COLUMNS_MAX + 1);
    localparam int LCW = $clog2(LINES_MAX + 1);

    // configuration
    logic [31:0] frame_gap_reg;
    logic [4:0]  data_lane_reg;
    logic [4:0]  word_length_reg;
    logic        msb_first_reg;
    logic [7:0]  marker_first_reg;
    logic [7:0]  marker_second_reg;
    logic [5:0]  column_limit_reg;

    // decoder state
    logic                in_frame_reg, in_frame_next;
    logic [BCW-1:0]      bit_count_reg, bit_count_next;
    logic                overflow_seen_reg, overflow_seen_next;
    logic [WINDOW_W-1:0] bit_window_reg, bit_window_next;
    logic [BCW-1:0]      scan_start_reg, scan_start_next;
    logic                reading_line_reg, reading_line_next;
    logic [NWW-1:0]      next_word_end_reg, next_word_end_next;
    logic [CCW-1:0]      column_count_reg, column_count_next;
    logic [LCW-1:0]      line_count_reg, line_count_next;
    logic [7:0]          garbled_count_reg, garbled_count_next;
    logic [31:0]         last_edge_time_reg, last_edge_time_next;

    // output buffer
    result_t head_reg, head_next;
    result_t skid_reg, skid_next;
    logic    head_valid_reg, head_valid_next;
    logic    skid_valid_reg, skid_valid_next;

    logic    accept_in;
    logic    pop_out;
    logic    res_valid;
    result_t res;
    result_t summary;
    logic [4:0]     wb;
    logic [CCW-1:0] cols;

    assign accept_in    = sample.valid && sample.ready;
    assign pop_out      = head_valid_reg && result.ready;
    assign sample.ready = !skid_valid_reg;
    assign cfg.ready    = 1'b1;

    always_comb
    begin
        if (word_length_reg < 5'(WORD_LEN_MIN))
        begin
            wb = 5'(WORD_LEN_MIN);
        end
        else if (word_length_reg > 5'(WORD_LEN_MAX))
        begin
            wb = 5'(WORD_LEN_MAX);
        end
        else
        begin
            wb = word_length_reg;
        end
        if ({1'b0, column_limit_reg} > 7'(COLUMNS_MAX))
        begin
            cols = CCW'(COLUMNS_MAX);
        end
        else
        begin
            cols = CCW'(column_limit_reg);
        end
    end

    always_comb
    begin
        summary                = '0;
        summary.kind           = KIND_SUMMARY;
        summary.frame_bits     = 10'(bit_count_reg);
        summary.frame_lines    = 3'(line_count_reg);
        summary.frame_overflow = overflow_seen_reg;
        summary.frame_garbled  = garbled_count_reg;
    end

    // frame and line decoding for one accepted word
    always_comb
    begin
        logic [31:0]    gap;
        logic           closing;
        logic [7:0]     d;
        logic [BCW-1:0] two_wb;

        in_frame_next       = in_frame_reg;
        bit_count_next      = bit_count_reg;
        overflow_seen_next  = overflow_seen_reg;
        bit_window_next     = bit_window_reg;
        scan_start_next     = scan_start_reg;
        reading_line_next   = reading_line_reg;
        next_word_end_next  = next_word_end_reg;
        column_count_next   = column_count_reg;
        line_count_next     = line_count_reg;
        garbled_count_next  = garbled_count_reg;
        last_edge_time_next = last_edge_time_reg;
        res_valid           = 1'b0;
        res                 = '0;
        gap                 = sample.edge_time_us - last_edge_time_reg;
        closing             = in_frame_reg && (gap >= frame_gap_reg);
        d                   = '0;
        two_wb              = BCW'({wb, 1'b0});

        if (accept_in)
        begin
            if (sample.operation == OP_FLUSH)
            begin
                if (in_frame_reg)
                begin
                    in_frame_next = 1'b0;
                    res_valid     = (bit_count_reg != '0);
                    res           = summary;
                end
            end
            else
            begin
                last_edge_time_next = sample.edge_time_us;
                if (closing)
                begin
                    res_valid = (bit_count_reg != '0);
                    res       = summary;
                end
                if (!in_frame_reg || closing)
                begin
                    in_frame_next      = 1'b1;
                    bit_count_next     = '0;
                    overflow_seen_next = 1'b0;
                    bit_window_next    = '0;
                    scan_start_next    = '0;
                    reading_line_next  = 1'b0;
                    next_word_end_next = '0;
                    column_count_next  = '0;
                    line_count_next    = '0;
                    garbled_count_next = '0;
                end
                if (bit_count_next >= BCW'(FRAME_BITS_MAX))
                begin
                    overflow_seen_next = 1'b1;
                end
                else
                begin
                    bit_window_next = {bit_window_next[WINDOW_W-2:0],
                                       sample.port_word[data_lane_reg]};
                    bit_count_next  = bit_count_next + BCW'(1);
                    if (!res_valid)
                    begin
                        if (reading_line_next)
                        begin
                            if (NWW'(bit_count_next) == next_word_end_next)
                            begin
                                d              = payload(bit_window_next, 5'd0, msb_first_reg);
                                res_valid      = 1'b1;
                                res.kind       = KIND_CHAR;
                                res.line_index = 2'(line_count_next - LCW'(1));
                                res.column     = 5'(column_count_next);
                                if (d >= PRINT_LO && d < PRINT_END)
                                begin
                                    res.char_code = d;
                                end
                                else
                                begin
                                    res.char_code = GARBLE_CHAR;
                                    res.garbled   = 1'b1;
                                    if (garbled_count_next != 8'hFF)
                                    begin
                                        garbled_count_next = garbled_count_next + 8'd1;
                                    end
                                end
                                column_count_next = column_count_next + CCW'(1);
                                if (column_count_next >= cols)
                                begin
                                    reading_line_next = 1'b0;
                                    scan_start_next   = bit_count_next;
                                    res.line_full     = 1'b1;
                                end
                                else
                                begin
                                    next_word_end_next = NWW'(bit_count_next) + NWW'(wb);
                                end
                            end
                        end
                        else if (line_count_next < LCW'(LINES_MAX)
                                 && bit_count_next >= two_wb
                                 && (bit_count_next - two_wb) >= scan_start_next
                                 && payload(bit_window_next, wb, msb_first_reg)
                                    == marker_first_reg
                                 && payload(bit_window_next, 5'd0, msb_first_reg)
                                    == marker_second_reg)
                        begin
                            line_count_next   = line_count_next + LCW'(1);
                            column_count_next = '0;
                            if (cols == '0)
                            begin
                                scan_start_next = bit_count_next;
                            end
                            else
                            begin
                                reading_line_next  = 1'b1;
                                next_word_end_next = NWW'(bit_count_next) + NWW'(wb);
                            end
                        end
                    end
                end
            end
        end
    end

    // two-entry output buffer
    always_comb
    begin
        head_next       = head_reg;
        skid_next       = skid_reg;
        head_valid_next = head_valid_reg;
        skid_valid_next = skid_valid_reg;
        if (skid_valid_reg)
        begin
            if (pop_out)
            begin
                head_next       = skid_reg;
                skid_valid_next = 1'b0;
            end
        end
        else if (res_valid)
        begin
            if (!head_valid_reg || pop_out)
            begin
                head_next       = res;
                head_valid_next = 1'b1;
            end
            else
            begin
                skid_next       = res;
                skid_valid_next = 1'b1;
            end
        end
        else if (pop_out)
        begin
            head_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_gap_reg     <= 32'd2000;
            data_lane_reg     <= 5'd0;
            word_length_reg   <= 5'd9;
            msb_first_reg     <= 1'b1;
            marker_first_reg  <= 8'd0;
            marker_second_reg <= 8'd0;
            column_limit_reg  <= 6'd16;
        end
        else if (cfg.valid && cfg.ready)
        begin
            unique case (cfg.index)
                CFG_FRAME_GAP:     frame_gap_reg     <= cfg.data;
                CFG_DATA_LANE:     data_lane_reg     <= cfg.data[4:0];
                CFG_WORD_LENGTH:   word_length_reg   <= cfg.data[4:0];
                CFG_MSB_FIRST:     msb_first_reg     <= cfg.data[0];
                CFG_MARKER_FIRST:  marker_first_reg  <= cfg.data[7:0];
                CFG_MARKER_SECOND: marker_second_reg <= cfg.data[7:0];
                CFG_COLUMN_LIMIT:  column_limit_reg  <= cfg.data[5:0];
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_frame_reg       <= 1'b0;
            bit_count_reg      <= '0;
            overflow_seen_reg  <= 1'b0;
            bit_window_reg     <= '0;
            scan_start_reg     <= '0;
            reading_line_reg   <= 1'b0;
            next_word_end_reg  <= '0;
            column_count_reg   <= '0;
            line_count_reg     <= '0;
            garbled_count_reg  <= '0;
            last_edge_time_reg <= '0;
            head_valid_reg     <= 1'b0;
            skid_valid_reg     <= 1'b0;
        end
        else
        begin
            in_frame_reg       <= in_frame_next;
            bit_count_reg      <= bit_count_next;
            overflow_seen_reg  <= overflow_seen_next;
            bit_window_reg     <= bit_window_next;
            scan_start_reg     <= scan_start_next;
            reading_line_reg   <= reading_line_next;
            next_word_end_reg  <= next_word_end_next;
            column_count_reg   <= column_count_next;
            line_count_reg     <= line_count_next;
            garbled_count_reg  <= garbled_count_next;
            last_edge_time_reg <= last_edge_time_next;
            head_valid_reg     <= head_valid_next;
            skid_valid_reg     <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        head_reg <= head_next;
        skid_reg <= skid_next;
    end

    assign result.valid          = head_valid_reg;
    assign result.kind           = head_reg.kind;
    assign result.line_index     = head_reg.line_index;
    assign result.column         = head_reg.column;
    assign result.char_code      = head_reg.char_code;
    assign result.garbled        = head_reg.garbled;
    assign result.line_full      = head_reg.line_full;
    assign result.frame_bits     = head_reg.frame_bits;
    assign result.frame_lines    = head_reg.frame_lines;
    assign result.frame_overflow = head_reg.frame_overflow;
    assign result.frame_garbled  = head_reg.frame_garbled;

    `ASSERT_ALWAYS(a_skid_behind_head, clk, rst_n,
        !skid_valid_reg || head_valid_reg, "skid entry held without head entry")
    `ASSERT_ALWAYS(a_line_open_counted, clk, rst_n,
        !reading_line_reg || line_count_reg != '0, "reading a line with no line counted")
    `ASSERT_ALWAYS(a_bits_bounded, clk, rst_n,
        bit_count_reg <= BCW'(FRAME_BITS_MAX), "bit count beyond frame store")
    `ASSERT_NEXT(a_flush_closes, clk, rst_n,
        accept_in && sample.operation == OP_FLUSH, !in_frame_reg, "flush left frame open")

endmodule

`default_nettype wire
